// ===== rtl/e2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2d_pkg: shared types and constants for the epoch-seconds to date converter
// Holds the stage data types, the constant-division factors and the
// month-start tables for leap and common years.
// ----------------------------------------------------------------------------
package e2d_pkg;

	// Whole days since the epoch (at most 49710 for a 32-bit seconds count).
	typedef logic [15:0] days_t;
	// Number of complete four-year cycles.
	typedef logic [5:0]  cyc_t;
	// Day within a four-year cycle, 0..1460.
	typedef logic [10:0] crem_t;
	// Day within a year, 0..365.
	typedef logic [8:0]  doy_t;
	// Elapsed whole years, 0..136.
	typedef logic [7:0]  years_t;
	// Month index, 0..11.
	typedef logic [3:0]  midx_t;

	// Seconds per day is 2^7 * 675; the power of two is removed by a shift.
	localparam int unsigned SecsShift  = 7;
	localparam int unsigned DayOdd     = 675;
	// floor(2^35 / 675): a quotient estimate that is exact or one low.
	localparam int unsigned DayRecipSh = 35;
	localparam logic [25:0] DayRecip   = 26'd50903316;

	// Days in a four-year cycle and floor(2^26 / 1461).
	localparam int unsigned CycDays    = 1461;
	localparam int unsigned CycRecipSh = 26;
	localparam logic [15:0] CycRecip   = 16'd45933;

	// Cycle day boundaries at which cycle years one, two and three begin.
	localparam crem_t Year1Start = 11'd366;
	localparam crem_t Year2Start = 11'd731;
	localparam crem_t Year3Start = 11'd1096;

	// Day of year on which each month begins.
	localparam doy_t LeapStart [12] = '{
		9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
		9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
	};
	localparam doy_t CommonStart [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// Reset value of the base year register.
	localparam logic [11:0] BaseYearReset = 12'd2020;

	// First day of month idx, in a leap or common year.
	function automatic doy_t month_start(input logic leap, input midx_t idx);
		doy_t v;
		v = '0;
		if (idx < 4'd12) begin
			v = leap ? LeapStart[idx] : CommonStart[idx];
		end
		return v;
	endfunction

endpackage

// ===== rtl/e2d_days.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2d_days: seconds to four-year cycle and day within cycle
// Four pipeline stages: a reciprocal multiply for the division by 86400,
// its one-step correction, a reciprocal multiply for the division by 1461
// and its correction. Stages advance together when en is high.
// ----------------------------------------------------------------------------
module e2d_days (
	input  logic                clk,
	input  logic                en,
	input  logic [31:0]         secs,
	output e2d_pkg::cyc_t       cyc,
	output e2d_pkg::crem_t      crem
);
	import e2d_pkg::*;

	logic [24:0] x_s1;
	logic [50:0] prod_day;
	logic [24:0] x_s2;
	logic [15:0] qd_s2;
	logic [25:0] qd_mul;
	logic [25:0] rd;
	days_t       days_s3;
	logic [31:0] prod_cyc;
	days_t       days_s4;
	cyc_t        qc_s4;
	logic [16:0] qc_mul;
	logic [15:0] rc;
	cyc_t        cyc_s5;
	crem_t       crem_s5;

	// Drop the power-of-two factor of the day length.
	assign x_s1 = secs[31:SecsShift];

	// Stage 2: estimate of days = x / 675.
	assign prod_day = 51'(x_s1) * 51'(DayRecip);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2  <= x_s1;
			qd_s2 <= prod_day[DayRecipSh +: 16];
		end
	end

	// Stage 3: correct the day estimate by one where the remainder overflows.
	assign qd_mul = 26'(qd_s2) * 26'(DayOdd);
	assign rd     = 26'(x_s2) - qd_mul;

	always_ff @(posedge clk) begin
		if (en) begin
			days_s3 <= (rd >= 26'(DayOdd)) ? qd_s2 + 16'd1 : qd_s2;
		end
	end

	// Stage 4: estimate of cycles = days / 1461.
	assign prod_cyc = 32'(days_s3) * 32'(CycRecip);

	always_ff @(posedge clk) begin
		if (en) begin
			days_s4 <= days_s3;
			qc_s4   <= prod_cyc[CycRecipSh +: 6];
		end
	end

	// Stage 5: correct the cycle estimate and keep the day within the cycle.
	assign qc_mul = 17'(qc_s4) * 17'(CycDays);
	assign rc     = days_s4 - qc_mul[15:0];

	always_ff @(posedge clk) begin
		if (en) begin
			if (rc >= 16'(CycDays)) begin
				cyc_s5  <= qc_s4 + 6'd1;
				crem_s5 <= 11'(rc - 16'(CycDays));
			end else begin
				cyc_s5  <= qc_s4;
				crem_s5 <= rc[10:0];
			end
		end
	end

	assign cyc  = cyc_s5;
	assign crem = crem_s5;

endmodule

// ===== rtl/epoch_seconds_to_date_top.sv =====
`timescale 1ns / 1ps
// An accepted item passes through stages one to six and the output register.
// Throughput: one item per cycle; the pipeline holds as a whole while the
// output register is full and stalled, and only then stalls the input.
// Reset: valid bits clear and base_year returns to 2020; data registers
// are not reset.
// ----------------------------------------------------------------------------
// epoch_seconds_to_date_top: seconds since epoch to calendar date
// Converts a 32-bit seconds count since the start of a leap base year into
// year, month and day, with a leap year at the start of every four-year cycle.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] base_year,
	// Seconds channel.
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [31:0] seconds,
	// Date channel.
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day
);
	import e2d_pkg::*;

	logic        en;
	logic [5:0]  vld_q;
	logic [11:0] base_year_q;
	logic [31:0] secs_s1;
	cyc_t        cyc_s5;
	crem_t       crem_s5;
	logic [1:0]  yic;
	doy_t        doy;
	years_t      years_s6;
	doy_t        doy_s6;
	logic        leap_s6;
	midx_t       midx;
	doy_t        mstart;
	logic        out_valid_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;

	// The whole pipeline moves unless a finished item waits at the output.
	assign en        = !(out_valid_q && rsp_stall);
	assign req_stall = !en;
	assign cfg_ready = 1'b1;

	// Base year register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_year_q <= BaseYearReset;
		end else if (cfg_valid && cfg_ready) begin
			base_year_q <= base_year;
		end
	end

	// Valid bits of stages one to six and of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[4:0], req_valid};
			out_valid_q <= vld_q[5];
		end
	end

	// Stage 1: input register.
	always_ff @(posedge clk) begin
		if (en) begin
			secs_s1 <= seconds;
		end
	end

	// Stages 2 to 5: days, then four-year cycles.
	e2d_days u_days (
		.clk  (clk),
		.en   (en),
		.secs (secs_s1),
		.cyc  (cyc_s5),
		.crem (crem_s5)
	);

	// Year within the cycle and day of that year.
	always_comb begin
		if (crem_s5 < Year1Start) begin
			yic = 2'd0;
			doy = 9'(crem_s5);
		end else if (crem_s5 < Year2Start) begin
			yic = 2'd1;
			doy = 9'(crem_s5 - Year1Start);
		end else if (crem_s5 < Year3Start) begin
			yic = 2'd2;
			doy = 9'(crem_s5 - Year2Start);
		end else begin
			yic = 2'd3;
			doy = 9'(crem_s5 - Year3Start);
		end
	end

	// Stage 6: elapsed years, day of year and leap flag.
	always_ff @(posedge clk) begin
		if (en) begin
			years_s6 <= {cyc_s5, yic};
			doy_s6   <= doy;
			leap_s6  <= (yic == 2'd0);
		end
	end

	// Month search: the last month whose first day is not after the day.
	always_comb begin
		midx = '0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s6 >= month_start(leap_s6, midx_t'(i))) begin
				midx = midx_t'(i);
			end
		end
		mstart = month_start(leap_s6, midx);
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			year_q  <= base_year_q + 12'(years_s6);
			month_q <= midx + 4'd1;
			day_q   <= 5'(doy_s6 - mstart + 9'd1);
		end
	end

	assign rsp_valid = out_valid_q;
	assign year      = year_q;
	assign month     = month_q;
	assign day       = day_q;

`ifndef SYNTHESIS
	// A delivered month is always in the calendar range.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (month >= 4'd1 && month <= 4'd12))
		else $error("month out of range");

	// A delivered day is always at least one.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (day != 5'd0))
		else $error("day is zero");

	// The corrected day remainder never reaches CycDays (1461).
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] |-> (crem_s5 < 11'd1461))
		else $error("cycle remainder out of range");

	// A held output freezes every stage, so the stage six item stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");
`endif

endmodule
